FILE: design/generational_handle_allocator_core_macros.svh
// assertion macros used by the allocator core
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define GHA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define GHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GHA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)

`define GHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: design/gha_pkg.sv
// types and constants of the generational handle allocator
`timescale 1ns / 1ps

package gha_pkg;

    localparam int SLOTS = 1024;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int GEN_W = 32;
    localparam int ENT_W = GEN_W + 1;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;
    localparam logic [1:0] OP_LOOKUP  = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] index;
        logic [GEN_W-1:0] generation;
    } gha_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] slot;
        logic [GEN_W-1:0] gen_out;
        logic             valid_res;
    } gha_out_t;

endpackage

FILE: design/generational_handle_allocator_core.sv
// Generational handle allocator: hands out slot/generation handles and
// checks them later.
// One input channel (s_valid/s_ready/s_data) carries a request word with an
// operation (create, destroy, validity query, lookup), a slot index and a
// generation. One result channel (m_valid/m_ready/m_data) returns exactly one
// word per request: status, slot, generation and the query answer.
// Requests are handled one at a time. A create served from the free stack
// passes through the pop and execute states before its result is registered,
// since the stack read and the generation table read are two dependent reads
// of rams with registered read data; every other request goes straight to
// execute (one table read, then modify and write back there).
// A new request is taken in the cycle after the previous result is
// registered; no request is accepted while another is still in progress.
// Reset clears the free count, the high-water mark and the control state;
// the tables need no clearing, because an entry is only consulted once it
// lies below the high-water mark and has been written.
// When the receiver stalls, the finished word waits in the output register
// and the next request stops before its write-back until that word is taken.
`timescale 1ns / 1ps

module generational_handle_allocator_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gha_pkg::gha_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output gha_pkg::gha_out_t m_data
);

    import gha_pkg::*;

    `include "generational_handle_allocator_core_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] fc_reg, fc_next;
    logic [CNT_W-1:0] hw_reg, hw_next;
    gha_in_t          req_reg;
    logic             m_valid_reg, m_valid_next;
    gha_out_t         m_data_reg, m_data_next;

    logic             accept;
    logic             out_free;
    logic             fc_nonzero;
    logic [CNT_W-1:0] fc_dec;

    logic             gen_we, gen_re;
    logic [IDX_W-1:0] gen_waddr, gen_raddr;
    logic [ENT_W-1:0] gen_wdata, gen_rdata;
    logic             stk_we, stk_re;
    logic [IDX_W-1:0] stk_waddr, stk_raddr;
    logic [IDX_W-1:0] stk_wdata, stk_rdata;

    logic             ent_occ;
    logic [GEN_W-1:0] ent_gen;
    logic [GEN_W-1:0] gen_inc;
    logic             slot_live;
    logic             handle_live;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == S_IDLE);
    assign out_free   = !m_valid_reg || m_ready;
    assign fc_nonzero = (fc_reg != '0);
    assign fc_dec     = fc_reg - CNT_W'(1);

    assign ent_occ     = gen_rdata[ENT_W-1];
    assign ent_gen     = gen_rdata[GEN_W-1:0];
    assign gen_inc     = (ent_gen + GEN_W'(1) == '0) ? GEN_W'(1) : ent_gen + GEN_W'(1);
    assign slot_live   = ({1'b0, req_reg.index} < hw_reg) && ent_occ;
    assign handle_live = (req_reg.generation != '0) && slot_live
                         && (ent_gen == req_reg.generation);

    gha_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .aclk  (aclk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (gen_re),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    gha_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_stk_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // read side
    always_comb begin
        stk_re    = accept && (s_data.op == OP_CREATE) && fc_nonzero;
        stk_raddr = fc_dec[IDX_W-1:0];
        gen_re    = accept || (state_reg == S_POP);
        gen_raddr = (state_reg == S_POP) ? stk_rdata : s_data.index;
    end

    // execute, write back, load result
    always_comb begin
        state_next   = state_reg;
        fc_next      = fc_reg;
        hw_next      = hw_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        gen_we       = 1'b0;
        gen_waddr    = req_reg.index;
        gen_wdata    = {1'b0, gen_inc};
        stk_we       = 1'b0;
        stk_waddr    = fc_reg[IDX_W-1:0];
        stk_wdata    = req_reg.index;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_data.op == OP_CREATE && fc_nonzero) ? S_POP : S_EXEC;
                end
            end
            S_POP: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next.status = ST_DONE;
                    unique case (req_reg.op)
                        OP_CREATE: begin
                            if (fc_nonzero) begin
                                gen_we              = 1'b1;
                                gen_waddr           = stk_rdata;
                                gen_wdata           = {1'b1, ent_gen};
                                fc_next             = fc_dec;
                                m_data_next.slot    = stk_rdata;
                                m_data_next.gen_out = ent_gen;
                            end else if (hw_reg != CNT_W'(SLOTS)) begin
                                gen_we              = 1'b1;
                                gen_waddr           = hw_reg[IDX_W-1:0];
                                gen_wdata           = {1'b1, GEN_W'(1)};
                                hw_next             = hw_reg + CNT_W'(1);
                                m_data_next.slot    = hw_reg[IDX_W-1:0];
                                m_data_next.gen_out = GEN_W'(1);
                            end else begin
                                m_data_next.status = ST_FULL;
                            end
                        end
                        OP_DESTROY: begin
                            if (handle_live) begin
                                gen_we    = 1'b1;
                                gen_wdata = {1'b0, gen_inc};
                                if (fc_reg != CNT_W'(SLOTS)) begin
                                    stk_we  = 1'b1;
                                    fc_next = fc_reg + CNT_W'(1);
                                end
                            end else begin
                                m_data_next.status = ST_INVALID;
                            end
                        end
                        OP_QUERY: begin
                            m_data_next.valid_res = handle_live;
                        end
                        OP_LOOKUP: begin
                            if (slot_live) begin
                                m_data_next.slot    = req_reg.index;
                                m_data_next.gen_out = ent_gen;
                            end
                        end
                        default: begin
                            m_data_next.status = ST_INVALID;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fc_reg      <= '0;
            hw_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fc_reg      <= fc_next;
            hw_reg      <= hw_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `GHA_ASSERT_SAME(a_fc_le_hw, aclk, aresetn, 1'b1, fc_reg <= hw_reg, "free count above high water")
    `GHA_ASSERT_SAME(a_hw_bound, aclk, aresetn, 1'b1, hw_reg <= CNT_W'(SLOTS), "high water beyond slots")
    `GHA_ASSERT_SAME(a_pop_nonempty, aclk, aresetn, state_reg == S_POP, fc_nonzero, "pop from empty stack")
    `GHA_ASSERT_NEXT(a_exec_hold, aclk, aresetn, state_reg == S_EXEC && !out_free, state_reg == S_EXEC && $stable(fc_reg) && $stable(hw_reg), "write-back while output stalled")

endmodule

FILE: design/gha_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
